// ===== rtl/core/rwr_pkg.sv =====
// ----------------------------------------------------------------------------
// rwr_pkg: shared types and constants for the reorder window ring
// Command and status codes, and the flags passed from the planner to the
// execute stage.
// ----------------------------------------------------------------------------
`default_nettype none

package rwr_pkg;

    // Command carried in the input tuser field
    typedef enum logic [1:0] {
        CMD_INSERT = 2'd0,
        CMD_POP    = 2'd1,
        CMD_CLEAR  = 2'd2,
        CMD_QUERY  = 2'd3
    } t_cmd;

    // Status carried in the result tuser field
    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_DROPPED  = 2'd1,
        ST_MISMATCH = 2'd2,
        ST_EMPTY    = 2'd3
    } t_status;

    // Insert plan flags
    typedef struct packed {
        logic ok;   // position is in range, so the insert is accepted
        logic ext;  // tail moves past the written slot
    } t_plan;

    localparam logic [6:0] RING_SIZE_RST = 7'd64;

    localparam int REL_W   = 7;
    localparam int TAG_W   = 16;
    localparam int FIELD_W = 6;   // width of slot, length, count, head fields

endpackage

`default_nettype wire

// ===== rtl/core/rwr_plan.sv =====
// ----------------------------------------------------------------------------
// rwr_plan: insert position planner
// Works out window length, acceptance, new head and physical slot of an
// insert from the pointer state that the item will see.
// ----------------------------------------------------------------------------
`default_nettype none

module rwr_plan #(
    parameter int PW = 6,
    parameter int SW = 7
) (
    input  wire logic [PW-1:0]                   i_head,
    input  wire logic [PW-1:0]                   i_tail,
    input  wire logic [SW-1:0]                   i_size,
    input  wire logic [rwr_pkg::REL_W-1:0]       i_rel,
    output rwr_pkg::t_plan                       o_plan,
    output logic      [PW-1:0]                   o_slot,
    output logic      [PW-1:0]                   o_start,
    output logic      [PW-1:0]                   o_next_tail
);

    localparam int XW = (SW > rwr_pkg::REL_W) ? SW : rwr_pkg::REL_W;
    localparam int CW = XW + 1;

    logic                          neg;
    logic [rwr_pkg::REL_W-1:0]     mag;
    logic [CW-1:0]                 head_c, tail_c, s_c, len, m, pos, sum;
    logic [CW-1:0]                 start_c, p_c, p1, ntail_c;

    assign neg    = i_rel[rwr_pkg::REL_W-1];
    assign mag    = ~i_rel + rwr_pkg::REL_W'(1);
    assign head_c = CW'(i_head);
    assign tail_c = CW'(i_tail);
    assign s_c    = CW'(i_size);
    assign m      = CW'(mag);
    assign pos    = CW'(i_rel[rwr_pkg::REL_W-2:0]);

    assign len = (tail_c >= head_c) ? (tail_c - head_c) : (tail_c + s_c - head_c);

    // downward growth keeps one slot free
    assign start_c = !neg ? head_c :
                     (head_c >= m) ? (head_c - m) : (head_c + s_c - m);

    assign sum     = head_c + pos;
    assign p_c     = neg ? start_c : ((sum >= s_c) ? (sum - s_c) : sum);
    assign p1      = p_c + CW'(1);
    assign ntail_c = (p1 == s_c) ? '0 : p1;

    assign o_plan.ok  = neg ? ((len + m) <= (s_c - CW'(1))) : (pos < (s_c - CW'(1)));
    assign o_plan.ext = !neg && (pos >= len);

    assign o_slot      = PW'(p_c);
    assign o_start     = PW'(start_c);
    assign o_next_tail = PW'(ntail_c);

endmodule

`default_nettype wire

// ===== rtl/core/rwr_tag_ram.sv =====
// ----------------------------------------------------------------------------
// rwr_tag_ram: group tag store
// One write port, two registered read ports, write data forwarded to a read
// of the same address in the same cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module rwr_tag_ram #(
    parameter int DEPTH    = 64,
    parameter int TAG_BITS = 16,
    parameter int AW       = 6
) (
    input  wire logic                i_clk,
    input  wire logic                i_wr_en,
    input  wire logic [AW-1:0]       i_wr_addr,
    input  wire logic [TAG_BITS-1:0] i_wr_data,
    input  wire logic                i_rd_a_en,
    input  wire logic [AW-1:0]       i_rd_a_addr,
    output logic      [TAG_BITS-1:0] o_rd_a_data,
    input  wire logic                i_rd_b_en,
    input  wire logic [AW-1:0]       i_rd_b_addr,
    output logic      [TAG_BITS-1:0] o_rd_b_data
);

    logic [TAG_BITS-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_a_en) begin
            if (i_wr_en && (i_wr_addr == i_rd_a_addr)) begin
                o_rd_a_data <= i_wr_data;
            end else begin
                o_rd_a_data <= mem[i_rd_a_addr];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_b_en) begin
            if (i_wr_en && (i_wr_addr == i_rd_b_addr)) begin
                o_rd_b_data <= i_wr_data;
            end else begin
                o_rd_b_data <= mem[i_rd_b_addr];
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/rwr_exec.sv =====
// ----------------------------------------------------------------------------
// rwr_exec: command execute
// Next pointer, count and occupancy state for one command, plus its status.
// ----------------------------------------------------------------------------
`default_nettype none

module rwr_exec #(
    parameter int DEPTH    = 64,
    parameter int TAG_BITS = 16,
    parameter int PW       = 6,
    parameter int SW       = 7
) (
    input  wire rwr_pkg::t_cmd          i_cmd,
    input  wire rwr_pkg::t_plan         i_plan,
    input  wire logic [PW-1:0]          i_slot,
    input  wire logic [PW-1:0]          i_start,
    input  wire logic [PW-1:0]          i_next_tail,
    input  wire logic [TAG_BITS-1:0]    i_tag,
    input  wire logic [TAG_BITS-1:0]    i_old_tag,
    input  wire logic [SW-1:0]          i_size,
    input  wire logic [PW-1:0]          i_head,
    input  wire logic [PW-1:0]          i_tail,
    input  wire logic [SW-1:0]          i_count,
    input  wire logic [DEPTH-1:0]       i_occ,
    output logic      [PW-1:0]          n_head,
    output logic      [PW-1:0]          n_tail,
    output logic      [SW-1:0]          n_count,
    output logic      [DEPTH-1:0]       n_occ,
    output logic                        o_wr,
    output rwr_pkg::t_status            o_status,
    output logic      [PW-1:0]          o_slot,
    output logic      [SW-1:0]          o_len
);

    logic          slot_occ, head_occ, mismatch;
    logic [SW-1:0] h1, head_s, tail_s;

    assign slot_occ = i_occ[i_slot];
    assign head_occ = i_occ[i_head];
    assign mismatch = slot_occ && (i_old_tag != i_tag);
    assign h1       = SW'(i_head) + SW'(1);

    always_comb begin
        n_head   = i_head;
        n_tail   = i_tail;
        n_count  = i_count;
        n_occ    = i_occ;
        o_wr     = 1'b0;
        o_status = rwr_pkg::ST_OK;
        o_slot   = '0;
        unique case (i_cmd)
            rwr_pkg::CMD_INSERT: begin
                if (!i_plan.ok) begin
                    o_status = rwr_pkg::ST_DROPPED;
                end else if (mismatch) begin
                    o_status = rwr_pkg::ST_MISMATCH;
                end else begin
                    if (!slot_occ) begin
                        n_occ[i_slot] = 1'b1;
                        n_count       = i_count + SW'(1);
                        o_wr          = 1'b1;
                    end
                    n_head = i_start;
                    if (i_plan.ext) begin
                        n_tail = i_next_tail;
                    end
                    o_slot = i_slot;
                end
            end
            rwr_pkg::CMD_POP: begin
                if (i_head == i_tail) begin
                    o_status = rwr_pkg::ST_EMPTY;
                end else begin
                    // a gap at the head advances without touching the count
                    if (head_occ) begin
                        n_occ[i_head] = 1'b0;
                        if (i_count != '0) begin
                            n_count = i_count - SW'(1);
                        end
                    end
                    n_head = (h1 == i_size) ? '0 : PW'(h1);
                end
            end
            rwr_pkg::CMD_CLEAR: begin
                n_head  = '0;
                n_tail  = '0;
                n_count = '0;
                n_occ   = '0;
            end
            rwr_pkg::CMD_QUERY: begin
            end
            default: begin
            end
        endcase
    end

    assign head_s = SW'(n_head);
    assign tail_s = SW'(n_tail);
    assign o_len  = (tail_s >= head_s) ? (tail_s - head_s) : (tail_s + i_size - head_s);

endmodule

`default_nettype wire

// ===== rtl/core/reorder_window_ring_unit.sv =====
// ----------------------------------------------------------------------------
// reorder_window_ring_unit: ring of group slots for packet reordering
//
// Usage:
//   Commands enter on the s_axis channel: tuser holds the command (insert,
//   pop head, clear all, query), tdata holds the relative index (signed)
//   and the group tag. Every command gives exactly one result item on the
//   m_axis channel: tuser holds the status, tdata the written slot, the
//   new-group flag, window length, group count and the head slot state.
//   From accept to result valid an item passes a plan register (tag store
//   read issued at accept) and a result register. One command per cycle is
//   sustained while m_axis_tready stays high; the limit is the single tag
//   compare against the tag read at accept, with the next plan forwarded
//   from the command in flight.
//   When m_axis_tready is low the result register holds, the plan stage
//   holds once it is full, and s_axis_tready drops; nothing is lost.
//   Reset: ring size 64, ring empty, both stages empty. Occupancy is held
//   in flops cleared by reset, so no clearing pass runs; tags are only used
//   behind a set occupancy bit. The user must write the ring size register
//   through i_cfg_wr_en/i_cfg_wr_data only while the block is idle; the block
//   does not enforce this. A write also empties the ring.
// ----------------------------------------------------------------------------
`default_nettype none

module reorder_window_ring_unit #(
    parameter int DEPTH    = 64,
    parameter int TAG_BITS = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // configuration: ring_size
    input  wire logic        i_cfg_wr_en,
    input  wire logic [6:0]  i_cfg_wr_data,
    // command channel
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [23:0] s_axis_tdata,   // [6:0] rel_index, [22:7] group_tag
    input  wire logic [1:0]  s_axis_tuser,   // [1:0] command
    // result channel
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic      [47:0] m_axis_tdata,   // [5:0] slot, [6] new_group,
                                             // [12:7] window_length,
                                             // [18:13] group_count,
                                             // [19] head_valid, [25:20] head_slot,
                                             // [41:26] head_tag
    output logic      [1:0]  m_axis_tuser    // [1:0] status
);

    localparam int PW = $clog2(DEPTH);       // slot pointer
    localparam int SW = $clog2(DEPTH + 1);   // size, length, count
    localparam int XW = (SW > 7) ? SW : 7;
    localparam int FW = rwr_pkg::FIELD_W;

    // ---------------- ring state ----------------
    logic [6:0]       r_ring_size;
    logic [PW-1:0]    r_head, r_tail;
    logic [SW-1:0]    r_count;
    logic [DEPTH-1:0] r_occ;
    logic [SW-1:0]    eff_size;
    logic [XW-1:0]    size_x;

    // ---------------- plan stage ----------------
    logic                 r_x_vld;
    rwr_pkg::t_cmd        r_x_cmd;
    logic [TAG_BITS-1:0]  r_x_tag;
    rwr_pkg::t_plan       r_x_plan;
    logic [PW-1:0]        r_x_slot, r_x_start, r_x_next_tail;
    logic [TAG_BITS-1:0]  x_old_tag;

    // ---------------- result stage ----------------
    logic                 r_o_vld;
    rwr_pkg::t_status     r_o_status;
    logic [FW-1:0]        r_o_slot, r_o_len, r_o_count, r_o_head;
    logic                 r_o_new, r_o_hvalid, r_o_head_occ;
    logic [TAG_BITS-1:0]  o_head_tag_raw;

    // ---------------- flow ----------------
    logic out_free, x_move, accept;

    assign out_free      = !r_o_vld || m_axis_tready;
    assign x_move        = r_x_vld && out_free;
    assign s_axis_tready = !r_x_vld || out_free;
    assign accept        = s_axis_tvalid && s_axis_tready;

    // ring_size saturated into [2, DEPTH]
    assign size_x   = XW'(r_ring_size);
    assign eff_size = (size_x < XW'(2))     ? SW'(2) :
                      (size_x > XW'(DEPTH)) ? SW'(DEPTH) : SW'(size_x);

    // ---------------- execute ----------------
    logic [PW-1:0]       n_head, n_tail, ex_slot;
    logic [SW-1:0]       n_count, ex_len;
    logic [DEPTH-1:0]    n_occ;
    logic                ex_wr;
    rwr_pkg::t_status    ex_status;

    rwr_exec #(
        .DEPTH    (DEPTH),
        .TAG_BITS (TAG_BITS),
        .PW       (PW),
        .SW       (SW)
    ) u_exec (
        .i_cmd       (r_x_cmd),
        .i_plan      (r_x_plan),
        .i_slot      (r_x_slot),
        .i_start     (r_x_start),
        .i_next_tail (r_x_next_tail),
        .i_tag       (r_x_tag),
        .i_old_tag   (x_old_tag),
        .i_size      (eff_size),
        .i_head      (r_head),
        .i_tail      (r_tail),
        .i_count     (r_count),
        .i_occ       (r_occ),
        .n_head      (n_head),
        .n_tail      (n_tail),
        .n_count     (n_count),
        .n_occ       (n_occ),
        .o_wr        (ex_wr),
        .o_status    (ex_status),
        .o_slot      (ex_slot),
        .o_len       (ex_len)
    );

    // ---------------- plan for the incoming item ----------------
    // Planned against the state the command in flight leaves behind.
    logic [PW-1:0]  st_head, st_tail, pl_slot, pl_start, pl_next_tail;
    rwr_pkg::t_plan pl_plan;

    assign st_head = x_move ? n_head : r_head;
    assign st_tail = x_move ? n_tail : r_tail;

    rwr_plan #(
        .PW (PW),
        .SW (SW)
    ) u_plan (
        .i_head      (st_head),
        .i_tail      (st_tail),
        .i_size      (eff_size),
        .i_rel       (s_axis_tdata[6:0]),
        .o_plan      (pl_plan),
        .o_slot      (pl_slot),
        .o_start     (pl_start),
        .o_next_tail (pl_next_tail)
    );

    // ---------------- tag store ----------------
    // Port A: tag of the planned slot, for the mismatch check.
    // Port B: tag of the head after the command, straight into the result.
    rwr_tag_ram #(
        .DEPTH    (DEPTH),
        .TAG_BITS (TAG_BITS),
        .AW       (PW)
    ) u_tag_ram (
        .i_clk       (i_clk),
        .i_wr_en     (x_move && ex_wr),
        .i_wr_addr   (r_x_slot),
        .i_wr_data   (r_x_tag),
        .i_rd_a_en   (accept),
        .i_rd_a_addr (pl_slot),
        .o_rd_a_data (x_old_tag),
        .i_rd_b_en   (x_move),
        .i_rd_b_addr (n_head),
        .o_rd_b_data (o_head_tag_raw)
    );

    // ---------------- control registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ring_size <= rwr_pkg::RING_SIZE_RST;
            r_head      <= '0;
            r_tail      <= '0;
            r_count     <= '0;
            r_occ       <= '0;
            r_x_vld     <= 1'b0;
            r_o_vld     <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                // new size empties the ring
                r_ring_size <= i_cfg_wr_data;
                r_head      <= '0;
                r_tail      <= '0;
                r_count     <= '0;
                r_occ       <= '0;
            end else if (x_move) begin
                r_head  <= n_head;
                r_tail  <= n_tail;
                r_count <= n_count;
                r_occ   <= n_occ;
            end

            if (accept) begin
                r_x_vld <= 1'b1;
            end else if (x_move) begin
                r_x_vld <= 1'b0;
            end

            if (x_move) begin
                r_o_vld <= 1'b1;
            end else if (m_axis_tready) begin
                r_o_vld <= 1'b0;
            end
        end
    end

    // ---------------- payload registers ----------------
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_x_cmd       <= rwr_pkg::t_cmd'(s_axis_tuser);
            r_x_tag       <= TAG_BITS'(s_axis_tdata[22:7]);
            r_x_plan      <= pl_plan;
            r_x_slot      <= pl_slot;
            r_x_start     <= pl_start;
            r_x_next_tail <= pl_next_tail;
        end
        if (x_move) begin
            r_o_status   <= ex_status;
            r_o_slot     <= FW'(ex_slot);
            r_o_new      <= ex_wr;
            r_o_len      <= FW'(ex_len);
            r_o_count    <= FW'(n_count);
            r_o_hvalid   <= (n_head != n_tail);
            r_o_head     <= FW'(n_head);
            r_o_head_occ <= n_occ[n_head];
        end
    end

    // ---------------- result channel ----------------
    assign m_axis_tvalid = r_o_vld;
    assign m_axis_tuser  = r_o_status;
    assign m_axis_tdata  = {6'd0,
                            r_o_head_occ ? rwr_pkg::TAG_W'(o_head_tag_raw)
                                         : rwr_pkg::TAG_W'(0),
                            r_o_head, r_o_hvalid, r_o_count, r_o_len,
                            r_o_new, r_o_slot};

endmodule

`default_nettype wire

// ===== test/reorder_window_ring_unit_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// reorder_window_ring_unit_test: self-checking bench for the reorder ring
// Sends insert, pop, clear and query commands with random gaps and result
// stalls, runs a bench-side model of the ring on each accepted item and
// compares every result item field by field, in order.
// ----------------------------------------------------------------------------

module reorder_window_ring_unit_test;

    localparam int RING_DEPTH = 64;

    // one result item, unpacked into its fields
    typedef struct {
        rwr_pkg::t_status status;
        logic [5:0]       slot;
        logic             new_group;
        logic [5:0]       win_len;
        logic [5:0]       grp_cnt;
        logic             head_valid;
        logic [5:0]       head_slot;
        logic [15:0]      head_tag;
    } t_ring_result;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_wr_en;
    logic [6:0]  i_cfg_wr_data;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata;   // [6:0] rel_index, [22:7] group_tag
    logic [1:0]  s_axis_tuser;   // [1:0] command
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [47:0] m_axis_tdata;   // [5:0] slot, [6] new_group, [12:7] window_length,
                                 // [18:13] group_count, [19] head_valid,
                                 // [25:20] head_slot, [41:26] head_tag
    logic [1:0]  m_axis_tuser;   // [1:0] status

    // bench copy of the ring state
    logic [6:0]  mdl_ring_size;
    int unsigned mdl_head;
    int unsigned mdl_tail;
    int unsigned mdl_count;
    bit          mdl_occ [RING_DEPTH];
    logic [15:0] mdl_tag [RING_DEPTH];

    t_ring_result pending_results [$];
    int           err_count;
    bit           tx_gaps;
    bit           rx_stalls;

    reorder_window_ring_unit uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #3_000_000;
        $display("reorder_window_ring_unit_test NOT OK");
        $finish;
    end

    // ---------------------------------------------------------------- model

    // ring size in use, saturated into [2, depth]
    function automatic int unsigned ring_span();
        int unsigned s;
        s = mdl_ring_size;
        if (s < 2) s = 2;
        if (s > RING_DEPTH) s = RING_DEPTH;
        return s;
    endfunction

    function automatic int unsigned window_len(int unsigned s);
        return (mdl_tail >= mdl_head) ? mdl_tail - mdl_head : mdl_tail + s - mdl_head;
    endfunction

    function void empty_ring();
        mdl_head  = 0;
        mdl_tail  = 0;
        mdl_count = 0;
        foreach (mdl_occ[i]) mdl_occ[i] = 1'b0;
    endfunction

    // apply one command to the bench ring and queue the result it gives
    function void ring_command(rwr_pkg::t_cmd cmd, logic [6:0] rel_raw, logic [15:0] tag);
        int unsigned  s, len, start, idx, p, m;
        int           rel;
        bit           ok;
        t_ring_result r;
        s   = ring_span();
        rel = $signed(rel_raw);
        mdl_head = mdl_head % s;
        mdl_tail = mdl_tail % s;
        r.status    = rwr_pkg::ST_OK;
        r.slot      = '0;
        r.new_group = 1'b0;
        case (cmd)
            rwr_pkg::CMD_INSERT: begin
                len   = window_len(s);
                start = mdl_head;
                idx   = 0;
                ok    = 1'b1;
                if (rel < 0) begin
                    // grow downward only while one slot stays free
                    m = -rel;
                    if (len + m <= s - 1) start = (mdl_head + s - m) % s;
                    else ok = 1'b0;
                end else if (rel >= int'(s) - 1) begin
                    ok = 1'b0;
                end else begin
                    idx = rel;
                end
                if (!ok) begin
                    r.status = rwr_pkg::ST_DROPPED;
                end else begin
                    p = (idx + start) % s;
                    if (mdl_occ[p] && mdl_tag[p] != tag) begin
                        r.status = rwr_pkg::ST_MISMATCH;
                    end else begin
                        if (!mdl_occ[p]) begin
                            mdl_occ[p] = 1'b1;
                            mdl_tag[p] = tag;
                            mdl_count++;
                            r.new_group = 1'b1;
                        end
                        mdl_head = start;
                        if (idx >= window_len(s)) mdl_tail = (idx + start + 1) % s;
                        r.slot = 6'(p);
                    end
                end
            end
            rwr_pkg::CMD_POP: begin
                if (mdl_head == mdl_tail) begin
                    r.status = rwr_pkg::ST_EMPTY;
                end else begin
                    // a gap at the head advances without touching the count
                    if (mdl_occ[mdl_head]) begin
                        mdl_occ[mdl_head] = 1'b0;
                        if (mdl_count > 0) mdl_count--;
                    end
                    mdl_head = (mdl_head + 1) % s;
                end
            end
            rwr_pkg::CMD_CLEAR: empty_ring();
            default: ;
        endcase
        r.win_len    = 6'(window_len(s));
        r.grp_cnt    = 6'(mdl_count);
        r.head_valid = (mdl_head != mdl_tail);
        r.head_slot  = 6'(mdl_head);
        r.head_tag   = mdl_occ[mdl_head] ? mdl_tag[mdl_head] : 16'h0000;
        pending_results.push_back(r);
    endfunction

    // ----------------------------------------------------------- checking

    task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
        err_count++;
        if (err_count <= 40)
            $display("%0t ns: %s got %0h want %0h", $time, what, got, want);
    endtask

    task automatic check_result();
        t_ring_result want;
        if (pending_results.size() == 0) begin
            report_mismatch("result with nothing pending", m_axis_tdata, 0);
            return;
        end
        want = pending_results.pop_front();
        if (m_axis_tuser != want.status)
            report_mismatch("status", m_axis_tuser, want.status);
        if (m_axis_tdata[5:0] != want.slot)
            report_mismatch("slot", m_axis_tdata[5:0], want.slot);
        if (m_axis_tdata[6] != want.new_group)
            report_mismatch("new_group", m_axis_tdata[6], want.new_group);
        if (m_axis_tdata[12:7] != want.win_len)
            report_mismatch("window_length", m_axis_tdata[12:7], want.win_len);
        if (m_axis_tdata[18:13] != want.grp_cnt)
            report_mismatch("group_count", m_axis_tdata[18:13], want.grp_cnt);
        if (m_axis_tdata[19] != want.head_valid)
            report_mismatch("head_valid", m_axis_tdata[19], want.head_valid);
        if (m_axis_tdata[25:20] != want.head_slot)
            report_mismatch("head_slot", m_axis_tdata[25:20], want.head_slot);
        if (m_axis_tdata[41:26] != want.head_tag)
            report_mismatch("head_tag", m_axis_tdata[41:26], want.head_tag);
    endtask

    // result side: random stalls, check on every accepted item
    always @(posedge i_clk) begin
        m_axis_tready <= !(rx_stalls && $urandom_range(99) < 6);
        if (i_rst_n && m_axis_tvalid && m_axis_tready) check_result();
    end

    // ------------------------------------------------------------ stimulus

    // present one command and hold it until accepted
    task automatic send_item(rwr_pkg::t_cmd cmd, logic [6:0] rel, logic [15:0] tag);
        while (tx_gaps && $urandom_range(99) < 6) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {1'b0, tag, rel};
        s_axis_tuser  <= cmd;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        ring_command(cmd, rel, tag);
    endtask

    // stop sending and let every pending result drain
    task automatic wait_idle();
        int n;
        s_axis_tvalid <= 1'b0;
        for (n = 0; n < 5000 && pending_results.size() != 0; n++) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_ring_size(logic [6:0] value);
        wait_idle();
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        mdl_ring_size = value;
        empty_ring();
    endtask

    // mostly well-formed window traffic: inserts near the live window that
    // usually repeat the tag already held, pops, a few clears and queries
    task automatic random_item();
        int unsigned   s, len, roll, p;
        int            rel;
        rwr_pkg::t_cmd cmd;
        logic [15:0]   tag;
        s    = ring_span();
        len  = window_len(s);
        roll = $urandom_range(99);
        rel  = 0;
        tag  = 16'($urandom);
        if (roll < 60) begin
            cmd  = rwr_pkg::CMD_INSERT;
            roll = $urandom_range(99);
            if (roll < 70)
                rel = $urandom_range((len + 2 < s - 2) ? len + 2 : s - 2, 0);
            else if (roll < 85)
                rel = -int'($urandom_range(4, 1));
            else
                rel = int'($urandom_range(126)) - 63;
            if (rel >= 0 && rel < s)
                p = (mdl_head + rel) % s;
            else if (rel < 0 && -rel < s)
                p = (mdl_head + s + rel) % s;
            else
                p = mdl_head;
            if (mdl_occ[p] && $urandom_range(99) < 85) tag = mdl_tag[p];
        end else if (roll < 88) begin
            cmd = rwr_pkg::CMD_POP;
        end else if (roll < 92) begin
            cmd = rwr_pkg::CMD_CLEAR;
        end else begin
            cmd = rwr_pkg::CMD_QUERY;
        end
        send_item(cmd, 7'(rel), tag);
    endtask

    // --------------------------------------------------------------- tests

    task automatic test_empty_ring();
        send_item(rwr_pkg::CMD_QUERY, 7'sd0, 16'h0000);
        send_item(rwr_pkg::CMD_POP,   7'sd0, 16'h0000);   // pop on empty
        send_item(rwr_pkg::CMD_CLEAR, 7'sd0, 16'h0000);
    endtask

    task automatic test_insert_limits();
        send_item(rwr_pkg::CMD_INSERT, 7'sd0,  16'hFFFF);   // opens head slot
        send_item(rwr_pkg::CMD_INSERT, 7'sd0,  16'hFFFF);   // same tag again
        send_item(rwr_pkg::CMD_INSERT, 7'sd0,  16'h0000);   // tag mismatch
        send_item(rwr_pkg::CMD_INSERT, 7'sd62, 16'h5555);   // farthest legal, tail extends
        send_item(rwr_pkg::CMD_INSERT, 7'sd63, 16'h5555);   // too far
        send_item(rwr_pkg::CMD_INSERT, -7'sd1, 16'h5555);   // window full, no room below
        send_item(rwr_pkg::CMD_POP,    7'sd0,  16'h0000);   // occupied head
        send_item(rwr_pkg::CMD_POP,    7'sd0,  16'h0000);   // gap at head
        send_item(rwr_pkg::CMD_QUERY,  7'sd0,  16'h0000);
    endtask

    task automatic test_downward_growth();
        send_item(rwr_pkg::CMD_CLEAR,  7'sd0,   16'h0000);
        send_item(rwr_pkg::CMD_INSERT, -7'sd63, 16'hAAAA);  // deepest growth from empty
        send_item(rwr_pkg::CMD_INSERT, -7'sd1,  16'hAAAA);  // one free slot must remain
        send_item(rwr_pkg::CMD_INSERT, 7'sd5,   16'h1234);  // inside window, no tail move
        send_item(rwr_pkg::CMD_POP,    7'sd0,   16'h0000);
        send_item(rwr_pkg::CMD_QUERY,  7'sd0,   16'h0000);
    endtask

    task automatic test_smallest_ring();
        set_ring_size(7'd2);
        send_item(rwr_pkg::CMD_INSERT, 7'sd0,  16'h0001);
        send_item(rwr_pkg::CMD_INSERT, 7'sd1,  16'h0001);   // at size minus one: dropped
        send_item(rwr_pkg::CMD_INSERT, -7'sd1, 16'h0002);   // no room below
        send_item(rwr_pkg::CMD_POP,    7'sd0,  16'h0000);
        send_item(rwr_pkg::CMD_INSERT, -7'sd1, 16'h0003);   // from empty, head steps down to slot 0
        send_item(rwr_pkg::CMD_QUERY,  7'sd0,  16'h0000);
        send_item(rwr_pkg::CMD_POP,    7'sd0,  16'h0000);
        send_item(rwr_pkg::CMD_POP,    7'sd0,  16'h0000);   // empty again
    endtask

    // random traffic over several sizes, including saturating values
    task automatic test_random_windows();
        logic [6:0] sizes [8];
        int         i;
        sizes = '{7'd64, 7'd3, 7'd127, 7'd17, 7'd0, 7'd63, 7'd33, 7'd1};
        foreach (sizes[k]) begin
            set_ring_size(sizes[k]);
            for (i = 0; i < 100; i++) begin
                // hold off once per size until the pipe is empty
                if (i == 50) wait_idle();
                random_item();
            end
        end
    endtask

    // full rate on both sides
    task automatic test_back_to_back();
        int i;
        tx_gaps   = 1'b0;
        rx_stalls = 1'b0;
        set_ring_size(7'd64);
        for (i = 0; i < 150; i++) random_item();
        tx_gaps   = 1'b1;
        rx_stalls = 1'b1;
    endtask

    initial begin
        err_count     = 0;
        tx_gaps       = 1'b1;
        rx_stalls     = 1'b1;
        i_rst_n       <= 1'b0;
        i_cfg_wr_en   <= 1'b0;
        i_cfg_wr_data <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= rwr_pkg::CMD_QUERY;
        mdl_ring_size = rwr_pkg::RING_SIZE_RST;
        empty_ring();
        foreach (mdl_tag[i]) mdl_tag[i] = '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_ring();
        test_insert_limits();
        test_downward_growth();
        test_smallest_ring();
        test_random_windows();
        test_back_to_back();

        wait_idle();
        if (pending_results.size() != 0)
            report_mismatch("results never arrived", pending_results.size(), 0);
        if (err_count == 0)
            $display("reorder_window_ring_unit_test OK");
        else
            $display("reorder_window_ring_unit_test NOT OK");
        $finish;
    end

endmodule
